/* rtl/explicit_free_list_allocator_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the explicit free-list allocator
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef EXPLICIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define EXPLICIT_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Check a condition at every clock edge
`define EFLA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next
`define EFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/efla_pkg.sv */
// ---------------------------------------------------------------------------
// efla_pkg
// Shared types and constants of the free-list allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package efla_pkg;

  localparam int ADDR_W    = 16;
  localparam int SIZE_W    = 17;
  localparam int MIN_BLOCK = 32;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_IGNORED  = 2'd2
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [ADDR_W-1:0]   granted_address;
    logic [SIZE_W-1:0]   granted_size;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/efla_if.sv */
// ---------------------------------------------------------------------------
// efla_req_if / efla_rsp_if
// Valid/ready channels for allocator requests and results.
// ---------------------------------------------------------------------------
`default_nettype none

interface efla_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] request_size;
  logic [15:0] payload_address;
  logic        pointer_is_null;

  modport source (output valid, operation, request_size, payload_address,
                  pointer_is_null, input ready);
  modport sink   (input valid, operation, request_size, payload_address,
                  pointer_is_null, output ready);
endinterface

interface efla_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] granted_address;
  logic [16:0] granted_size;

  modport source (output valid, status, granted_address, granted_size, input ready);
  modport sink   (input valid, status, granted_address, granted_size, output ready);
endinterface

`default_nettype wire

/* rtl/efla_ram.sv */
// ---------------------------------------------------------------------------
// efla_ram
// Single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module efla_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write or read one word a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

/* rtl/efla_out_stage.sv */
// ---------------------------------------------------------------------------
// efla_out_stage
// Result register that holds one word until the sink takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module efla_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire efla_pkg::rsp_t rsp_i,
  output logic               free_o,
  efla_rsp_if.source         rsp_o
);
  import efla_pkg::*;

  logic valid_q, valid_d;
  rsp_t data_q;

  // Free when empty or the held word leaves this cycle
  assign free_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= rsp_i;
    end
  end

  assign rsp_o.valid           = valid_q;
  assign rsp_o.status          = data_q.status;
  assign rsp_o.granted_address = data_q.granted_address;
  assign rsp_o.granted_size    = data_q.granted_size;

endmodule

`default_nettype wire

/* rtl/explicit_free_list_allocator.sv */
// A null release goes straight to the result; an allocate takes the first free block
// that fits (split if the rest is large enough) or extends the break; a valid release
// retags, pushes and merges. One word in flight; the next can be accepted in the cycle
// after the result is loaded, and a result held at the output stalls the input. The
// single-port tag store carries every tag and link access. Async reset: heap empty,
// break at byte 8, no clearing pass.
// ---------------------------------------------------------------------------
// explicit_free_list_allocator
// First-fit boundary-tag heap allocator with a LIFO doubly linked free list.
// ---------------------------------------------------------------------------
`default_nettype none

module explicit_free_list_allocator #(
  parameter int HEAP_BYTES = 65536
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  efla_req_if.sink   req_i,
  efla_rsp_if.source rsp_o
);
  import efla_pkg::*;
  `include "explicit_free_list_allocator_assert.svh"

  localparam int WORDS = HEAP_BYTES / 8;
  localparam int AW    = $clog2(WORDS);
  localparam int DW    = $clog2(HEAP_BYTES) + 1;
  localparam int BW    = (($clog2(HEAP_BYTES) > 17) ? $clog2(HEAP_BYTES) : 17) + 2;
  localparam int CW    = AW + 1;

  typedef enum logic [28:0] {
    S_IDLE  = 29'b1 << 0,  S_W_HDR = 29'b1 << 1,  S_W_CHK = 29'b1 << 2,
    S_W_NXT = 29'b1 << 3,  S_EXT   = 29'b1 << 4,  S_A_SPL = 29'b1 << 5,
    S_A_PSH = 29'b1 << 6,  S_A_TAG = 29'b1 << 7,  S_R_HDR = 29'b1 << 8,
    S_R_FTR = 29'b1 << 9,  S_R_CHK = 29'b1 << 10, S_R_PSH = 29'b1 << 11,
    S_R_MR  = 29'b1 << 12, S_R_MRC = 29'b1 << 13, S_R_MRU = 29'b1 << 14,
    S_R_ML  = 29'b1 << 15, S_R_MLP = 29'b1 << 16, S_R_MLC = 29'b1 << 17,
    S_R_MLU = 29'b1 << 18, S_T1    = 29'b1 << 19, S_T2    = 29'b1 << 20,
    S_P1    = 29'b1 << 21, S_P2    = 29'b1 << 22, S_P3    = 29'b1 << 23,
    S_U1    = 29'b1 << 24, S_U2    = 29'b1 << 25, S_U3    = 29'b1 << 26,
    S_U4    = 29'b1 << 27, S_FIN   = 29'b1 << 28
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  logic [BW-1:0] head_q, head_d, first_q, first_d, last_q, last_d, hb_q, hb_d;
  logic [BW-1:0] need_q, need_d, b_q, b_d, bs_q, bs_d, n_q, n_d, gs_q, gs_d;
  logic [BW-1:0] ta_q, ta_d, ts_q, ts_d, node_q, node_d, cs_q, cs_d, l_q, l_d;
  logic [BW-1:0] nx_q, nx_d, pv_q, pv_d;
  logic [DW-1:0] h_q, h_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          tf_q, tf_d, op_q, op_d, pay_bad_q, pay_bad_d;
  status_e       status_q, status_d;

  logic [BW-1:0] mem_addr, rd_ext, rd_size, req_need, hsz, rem;
  logic [DW-1:0] mem_wdata, ram_rdata;
  logic          mem_we, out_free, out_load, hdr_ok;
  rsp_t          rsp_d;

  efla_ram #(.WIDTH(DW), .DEPTH(WORDS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr[AW+2:3]),
    .wdata_i (mem_wdata),
    .rdata_o (ram_rdata)
  );

  assign rd_ext   = BW'(ram_rdata);
  assign rd_size  = {rd_ext[BW-1:1], 1'b0};
  assign hsz      = BW'({h_q[DW-1:1], 1'b0});
  assign rem      = bs_q - need_q;
  assign req_need = ((BW'(req_i.request_size) + BW'(31)) & ~BW'(15)) < BW'(MIN_BLOCK)
                  ? BW'(MIN_BLOCK)
                  : ((BW'(req_i.request_size) + BW'(31)) & ~BW'(15));

  // Validate a release against the heap bounds and its boundary tags
  assign hdr_ok = !pay_bad_q && (first_q != '0) && (b_q >= first_q) && (b_q <= last_q)
               && h_q[0] && (hsz >= BW'(MIN_BLOCK)) && (hsz[3:0] == 4'd0)
               && (b_q + hsz <= hb_q) && (ram_rdata == h_q);

  assign req_i.ready = (state_q == S_IDLE);

  // Sequence the tag-store accesses
  always_comb begin
    state_d = state_q;  ret_d = ret_q;
    head_d = head_q;  first_d = first_q;  last_d = last_q;  hb_d = hb_q;
    need_d = need_q;  b_d = b_q;  bs_d = bs_q;  n_d = n_q;  gs_d = gs_q;
    ta_d = ta_q;  ts_d = ts_q;  tf_d = tf_q;  node_d = node_q;  cs_d = cs_q;
    l_d = l_q;  nx_d = nx_q;  pv_d = pv_q;  h_d = h_q;  cnt_d = cnt_q;
    op_d = op_q;  pay_bad_d = pay_bad_q;  status_d = status_q;
    mem_addr = '0;  mem_we = 1'b0;  mem_wdata = '0;  out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d      = req_i.operation;
          need_d    = req_need;
          b_d       = BW'(req_i.payload_address) - BW'(8);
          pay_bad_d = (req_i.payload_address < 16'd16) || (req_i.payload_address[3:0] != 4'd0);
          status_d  = STATUS_DONE;
          gs_d      = '0;
          n_d       = head_q;
          cnt_d     = '0;
          if (req_i.operation == OP_ALLOC) begin
            state_d = (head_q == '0) ? S_EXT : S_W_HDR;
          end else if (req_i.pointer_is_null) begin
            status_d = STATUS_IGNORED;
            state_d  = S_FIN;
          end else begin
            state_d = S_R_HDR;
          end
        end
      end
      // First-fit walk
      S_W_HDR: begin
        mem_addr = n_q;
        state_d  = S_W_CHK;
      end
      S_W_CHK: begin
        mem_addr = n_q + BW'(8);
        if (rd_size >= need_q) begin
          b_d = n_q;  bs_d = rd_size;  node_d = n_q;  ret_d = S_A_SPL;
          state_d = S_U1;
        end else begin
          state_d = S_W_NXT;
        end
      end
      S_W_NXT: begin
        n_d      = rd_ext;
        cnt_d    = cnt_q + CW'(1);
        mem_addr = rd_ext;
        state_d  = ((rd_ext == '0) || (cnt_q == CW'(WORDS - 1))) ? S_EXT : S_W_CHK;
      end
      // Extend the break
      S_EXT: begin
        if (hb_q + need_q > BW'(HEAP_BYTES)) begin
          status_d = STATUS_NO_SPACE;
          state_d  = S_FIN;
        end else begin
          b_d  = hb_q;
          hb_d = hb_q + need_q;
          if (first_q == '0) begin
            first_d = hb_q;
          end
          last_d = hb_q;  ta_d = hb_q;  ts_d = need_q;  tf_d = 1'b1;  gs_d = need_q;
          ret_d = S_FIN;  state_d = S_T1;
        end
      end
      S_A_SPL: begin
        if (rem >= BW'(MIN_BLOCK)) begin
          ta_d = b_q + need_q;  ts_d = rem;  tf_d = 1'b0;  gs_d = need_q;
          if (b_q == last_q) begin
            last_d = b_q + need_q;
          end
          ret_d = S_A_PSH;  state_d = S_T1;
        end else begin
          gs_d = bs_q;  state_d = S_A_TAG;
        end
      end
      S_A_PSH: begin
        node_d = b_q + need_q;  ret_d = S_A_TAG;  state_d = S_P1;
      end
      S_A_TAG: begin
        ta_d = b_q;  ts_d = gs_q;  tf_d = 1'b1;  ret_d = S_FIN;  state_d = S_T1;
      end
      // Release: read and check the tags
      S_R_HDR: begin
        mem_addr = b_q;
        state_d  = S_R_FTR;
      end
      S_R_FTR: begin
        h_d      = ram_rdata;
        mem_addr = b_q + rd_size - BW'(8);
        state_d  = S_R_CHK;
      end
      S_R_CHK: begin
        if (!hdr_ok) begin
          status_d = STATUS_IGNORED;
          state_d  = S_FIN;
        end else begin
          cs_d = hsz;  ta_d = b_q;  ts_d = hsz;  tf_d = 1'b0;
          ret_d = S_R_PSH;  state_d = S_T1;
        end
      end
      S_R_PSH: begin
        node_d = b_q;  ret_d = S_R_MR;  state_d = S_P1;
      end
      // Merge with the right neighbour
      S_R_MR: begin
        if (b_q < last_q) begin
          mem_addr = b_q + cs_q;
          state_d  = S_R_MRC;
        end else begin
          state_d = S_R_ML;
        end
      end
      S_R_MRC: begin
        if (rd_ext[0]) begin
          state_d = S_R_ML;
        end else begin
          node_d = b_q + cs_q;
          if (b_q + cs_q == last_q) begin
            last_d = b_q;
          end
          ta_d = b_q;  ts_d = cs_q + rd_size;  cs_d = cs_q + rd_size;  tf_d = 1'b0;
          ret_d = S_R_MRU;  state_d = S_T1;
        end
      end
      S_R_MRU: begin
        ret_d = S_R_ML;  state_d = S_U1;
      end
      // Merge with the left neighbour
      S_R_ML: begin
        if (b_q > first_q) begin
          mem_addr = b_q - BW'(8);
          state_d  = S_R_MLP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_R_MLP: begin
        l_d      = b_q - rd_size;
        mem_addr = b_q - rd_size;
        state_d  = S_R_MLC;
      end
      S_R_MLC: begin
        if (rd_ext[0]) begin
          state_d = S_FIN;
        end else begin
          node_d = b_q;
          if (b_q == last_q) begin
            last_d = l_q;
          end
          ta_d = l_q;  ts_d = rd_size + cs_q;  tf_d = 1'b0;
          ret_d = S_R_MLU;  state_d = S_T1;
        end
      end
      S_R_MLU: begin
        ret_d = S_FIN;  state_d = S_U1;
      end
      // Write header and footer
      S_T1: begin
        mem_we = 1'b1;  mem_addr = ta_q;  mem_wdata = DW'(ts_q) | DW'(tf_q);
        state_d = S_T2;
      end
      S_T2: begin
        mem_we = 1'b1;  mem_addr = ta_q + ts_q - BW'(8);  mem_wdata = DW'(ts_q) | DW'(tf_q);
        state_d = ret_q;
      end
      // Push a node on the list head
      S_P1: begin
        mem_we = 1'b1;  mem_addr = node_q + BW'(16);  mem_wdata = '0;
        state_d = S_P2;
      end
      S_P2: begin
        mem_we = 1'b1;  mem_addr = node_q + BW'(8);  mem_wdata = DW'(head_q);
        state_d = S_P3;
      end
      S_P3: begin
        if (head_q != '0) begin
          mem_we = 1'b1;  mem_addr = head_q + BW'(16);  mem_wdata = DW'(node_q);
        end
        head_d  = node_q;
        state_d = ret_q;
      end
      // Unlink a node from the list
      S_U1: begin
        mem_addr = node_q + BW'(8);
        state_d  = S_U2;
      end
      S_U2: begin
        nx_d     = rd_ext;
        mem_addr = node_q + BW'(16);
        state_d  = S_U3;
      end
      S_U3: begin
        pv_d = rd_ext;
        if (rd_ext == '0) begin
          head_d = nx_q;
        end else begin
          mem_we = 1'b1;  mem_addr = rd_ext + BW'(8);  mem_wdata = DW'(nx_q);
        end
        state_d = S_U4;
      end
      S_U4: begin
        if (nx_q != '0) begin
          mem_we = 1'b1;  mem_addr = nx_q + BW'(16);  mem_wdata = DW'(pv_q);
        end
        state_d = ret_q;
      end
      // Hand the result word to the output register
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Form the result word
  always_comb begin
    rsp_d.status          = status_q;
    rsp_d.granted_address = '0;
    rsp_d.granted_size    = '0;
    if ((op_q == OP_ALLOC) && (status_q == STATUS_DONE)) begin
      rsp_d.granted_address = ADDR_W'(b_q + BW'(8));
      rsp_d.granted_size    = SIZE_W'(gs_q);
    end
  end

  efla_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .rsp_i  (rsp_d),
    .free_o (out_free),
    .rsp_o  (rsp_o)
  );

  // Control and heap pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      head_q  <= '0;
      first_q <= '0;
      last_q  <= '0;
      hb_q    <= BW'(8);
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      head_q  <= head_d;
      first_q <= first_d;
      last_q  <= last_d;
      hb_q    <= hb_d;
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk_i) begin
    need_q <= need_d;  b_q <= b_d;  bs_q <= bs_d;  n_q <= n_d;  gs_q <= gs_d;
    ta_q <= ta_d;  ts_q <= ts_d;  tf_q <= tf_d;  node_q <= node_d;  cs_q <= cs_d;
    l_q <= l_d;  nx_q <= nx_d;  pv_q <= pv_d;  h_q <= h_d;  cnt_q <= cnt_d;
    op_q <= op_d;  pay_bad_q <= pay_bad_d;  status_q <= status_d;
  end

  `EFLA_ASSERT(a_break_aligned, hb_q[3:0] == 4'd8, "heap break lost its alignment")
  `EFLA_ASSERT(a_break_bound, hb_q <= BW'(HEAP_BYTES), "heap break past capacity")
  `EFLA_ASSERT(a_head_aligned, (head_q == '0) || (head_q[3:0] == 4'd8), "free list head misaligned")
  `EFLA_ASSERT_NEXT(a_busy_after_accept, req_i.valid && req_i.ready, state_q != S_IDLE, "accepted word not worked on")

endmodule

`default_nettype wire

/* verif/explicit_free_list_allocator_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// explicit_free_list_allocator_tb
// Drives allocate and release words into the heap allocator with random gaps
// on both channels, predicts every result with a word-level model of the
// boundary-tag heap and free list, and checks each result field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module explicit_free_list_allocator_tb;
  import efla_pkg::*;

  localparam int HEAP_BYTES = 65536;
  localparam int HEAP_WORDS = HEAP_BYTES / 8;
  localparam int IDLE_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RSP_HOLD_CYCLES = 300;

  logic clk_i;
  logic rst_ni;

  efla_req_if req_if ();
  efla_rsp_if rsp_if ();

  explicit_free_list_allocator #(.HEAP_BYTES(HEAP_BYTES)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Heap image and bookkeeping of the predictor
  int unsigned heap_word [HEAP_WORDS];
  int unsigned list_head, lowest_block, highest_block, brk;

  rsp_t        pending_rsp[$];
  logic [15:0] live_ptr[$];
  logic [15:0] stale_ptr[$];
  int          error_count = 0;
  bit          quiet;
  bit          hold_on = 1'b0;
  event        hold_start;
  int          idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned peek(int unsigned a);
    return ((a >> 3) < HEAP_WORDS) ? heap_word[a >> 3] : 0;
  endfunction

  function automatic void poke(int unsigned a, int unsigned v);
    if ((a >> 3) < HEAP_WORDS) heap_word[a >> 3] = v;
  endfunction

  function automatic void write_tags(int unsigned b, int unsigned sz, int unsigned used);
    poke(b, sz | used);
    poke(b + sz - 8, sz | used);
  endfunction

  function automatic void unlink_free(int unsigned n);
    int unsigned nx, pv;
    nx = peek(n + 8);
    pv = peek(n + 16);
    if (pv == 0) list_head = nx;
    else poke(pv + 8, nx);
    if (nx != 0) poke(nx + 16, pv);
  endfunction

  function automatic void push_free(int unsigned n);
    poke(n + 16, 0);
    poke(n + 8, list_head);
    if (list_head != 0) poke(list_head + 16, n);
    list_head = n;
  endfunction

  function automatic void coalesce(int unsigned l, int unsigned r);
    int unsigned lh, rh;
    lh = peek(l);
    rh = peek(r);
    if (lh[0] || rh[0]) return;
    write_tags(l, (lh & ~32'd1) + (rh & ~32'd1), 0);
    unlink_free(r);
    if (r == highest_block) highest_block = l;
  endfunction

  // Work out the result of one word and update the heap image
  function automatic rsp_t predict_heap(logic op, logic [15:0] req_sz, logic [15:0] pay,
                                        logic is_null);
    rsp_t        r;
    int unsigned need, b, bs, h, sz, n, walked, ps;
    bit          ok;
    r.status = STATUS_DONE;
    r.granted_address = '0;
    r.granted_size = '0;
    if (op == OP_ALLOC) begin
      need = (16 + req_sz + 15) & ~32'd15;
      if (need < MIN_BLOCK) need = MIN_BLOCK;
      b = 0;
      n = list_head;
      walked = 0;
      while (n != 0 && walked < HEAP_WORDS) begin
        if ((peek(n) & ~32'd1) >= need) begin
          b = n;
          break;
        end
        n = peek(n + 8);
        walked++;
      end
      if (b != 0) begin
        bs = peek(b) & ~32'd1;
        unlink_free(b);
        if (bs - need >= MIN_BLOCK) begin
          write_tags(b + need, bs - need, 0);
          if (b == highest_block) highest_block = b + need;
          push_free(b + need);
          write_tags(b, need, 1);
          r.granted_size = SIZE_W'(need);
        end else begin
          write_tags(b, bs, 1);
          r.granted_size = SIZE_W'(bs);
        end
        r.granted_address = 16'(b + 8);
      end else if (brk + need > HEAP_BYTES) begin
        r.status = STATUS_NO_SPACE;
      end else begin
        b = brk;
        brk += need;
        if (lowest_block == 0) lowest_block = b;
        highest_block = b;
        write_tags(b, need, 1);
        r.granted_address = 16'(b + 8);
        r.granted_size = SIZE_W'(need);
      end
    end else if (is_null) begin
      r.status = STATUS_IGNORED;
    end else begin
      b = pay - 8;
      h = peek(b);
      sz = h & ~32'd1;
      ok = pay >= 16 && pay[3:0] == 0 && lowest_block != 0 && b >= lowest_block &&
           b <= highest_block && h[0] && sz >= MIN_BLOCK && sz[3:0] == 0 &&
           b + sz <= brk;
      if (ok) ok = peek(b + sz - 8) == h;
      if (!ok) begin
        r.status = STATUS_IGNORED;
      end else begin
        write_tags(b, sz, 0);
        push_free(b);
        if (b < highest_block) coalesce(b, b + sz);
        if (b > lowest_block) begin
          ps = peek(b - 8) & ~32'd1;
          coalesce(b - ps, b);
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // Offer one word, wait for it to be taken, then record its expected result
  task automatic send_word(logic op, logic [15:0] req_sz, logic [15:0] pay, logic is_null);
    int   gap;
    rsp_t want;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.operation       <= op;
    req_if.request_size    <= req_sz;
    req_if.payload_address <= pay;
    req_if.pointer_is_null <= is_null;
    do @(posedge clk_i); while (!req_if.ready);
    want = predict_heap(op, req_sz, pay, is_null);
    pending_rsp.push_back(want);
    if (op == OP_ALLOC && want.status == STATUS_DONE) live_ptr.push_back(want.granted_address);
  endtask

  task automatic alloc_word(int unsigned sz);
    send_word(OP_ALLOC, 16'(sz), 16'($urandom), 1'b0);
  endtask

  // Release the live block at index idx and remember it for double releases
  task automatic release_live(int idx);
    logic [15:0] p;
    p = live_ptr[idx];
    live_ptr.delete(idx);
    stale_ptr.push_back(p);
    if (stale_ptr.size() > 64) void'(stale_ptr.pop_front());
    send_word(OP_FREE, 16'($urandom), p, 1'b0);
  endtask

  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Hold the result side off for a long stretch once asked
  always @(hold_start) begin
    hold_on = 1'b1;
    repeat (RSP_HOLD_CYCLES) @(posedge clk_i);
    hold_on = 1'b0;
  end

  // Check results against the oldest expectation; pace the ready line
  int rsp_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_gap = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected result words", 1, 0);
        end else begin
          rsp_t want;
          want = pending_rsp.pop_front();
          if (rsp_if.status != want.status)
            report_mismatch("status", rsp_if.status, want.status);
          if (rsp_if.granted_address != want.granted_address)
            report_mismatch("granted_address", rsp_if.granted_address, want.granted_address);
          if (rsp_if.granted_size != want.granted_size)
            report_mismatch("granted_size", rsp_if.granted_size, want.granted_size);
        end
        rsp_gap = quiet ? 0 : $urandom_range(0, 6);
      end
      if (hold_on) begin
        rsp_if.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
        rsp_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no word moved on either channel
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("explicit_free_list_allocator_tb failed");
      $finish;
    end
  end

  // Size rounding, minimum block and growth of the break
  task automatic test_rounding();
    alloc_word(0);
    alloc_word(1);
    alloc_word(16);
    alloc_word(17);
    alloc_word(48);
    alloc_word(100);
  endtask

  // Releases, one merging with its right neighbour, and reuse of freed blocks without a split
  task automatic test_merge_reuse();
    release_live(1);
    release_live(2);
    release_live(0);
    alloc_word(40);
    alloc_word(0);
    release_live(live_ptr.size() - 1);
    alloc_word(16);
  endtask

  // Null, double and stale releases; the last names a block allocated again, so it is freed
  task automatic test_ignored_release();
    send_word(OP_FREE, 16'hFFFF, 16'hFFFF, 1'b1);
    send_word(OP_FREE, 16'h0000, 16'h0000, 1'b1);
    send_word(OP_FREE, 16'h0, stale_ptr[0], 1'b0);
    send_word(OP_FREE, 16'h0, stale_ptr[stale_ptr.size() - 1], 1'b0);
  endtask

  // Requests too large for the heap, then one large request that still fits
  task automatic test_no_space();
    alloc_word(65535);
    alloc_word(65504);
    alloc_word(32768);
  endtask

  task automatic test_random(int count);
    int r, sz;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 5 && !quiet) quiet = 1'b1;
      else if (r < 10) quiet = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 50 || (r < 90 && live_ptr.size() == 0)) begin
        sz = $urandom_range(0, 99);
        if (sz < 80) alloc_word($urandom_range(0, 96));
        else if (sz < 97) alloc_word($urandom_range(0, 2048));
        else alloc_word($urandom_range(0, 65535));
      end else if (r < 90) begin
        release_live($urandom_range(0, live_ptr.size() - 1));
      end else if (r < 95 && stale_ptr.size() != 0) begin
        send_word(OP_FREE, 16'($urandom), stale_ptr[$urandom_range(0, stale_ptr.size() - 1)],
                  1'b0);
      end else begin
        send_word(OP_FREE, 16'($urandom), 16'($urandom), 1'b1);
      end
    end
    quiet = 1'b0;
  endtask

  // Hold the result side off while words keep coming, so the input stalls
  task automatic test_backpressure();
    -> hold_start;
    repeat (6) alloc_word($urandom_range(0, 64));
    repeat (4) begin
      if (live_ptr.size() != 0) release_live($urandom_range(0, live_ptr.size() - 1));
      else send_word(OP_FREE, 16'($urandom), 16'($urandom), 1'b1);
    end
  endtask

  initial begin
    rst_ni                 = 1'b0;
    req_if.valid           = 1'b0;
    req_if.operation       = OP_ALLOC;
    req_if.request_size    = '0;
    req_if.payload_address = '0;
    req_if.pointer_is_null = 1'b0;
    quiet         = 1'b0;
    list_head     = 0;
    lowest_block  = 0;
    highest_block = 0;
    brk           = 8;
    foreach (heap_word[i]) heap_word[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_rounding();
    test_merge_reuse();
    test_ignored_release();
    test_no_space();
    test_random(480);
    test_backpressure();

    req_if.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("explicit_free_list_allocator_tb passed");
    end else begin
      $display("explicit_free_list_allocator_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
